// ===== rtl/core/itrd_pkg.sv =====
`timescale 1ns / 1ps
package itrd_pkg;

  localparam int unsigned ValueW      = 64;
  localparam int unsigned RadixW      = 5;
  localparam int unsigned DigitW      = 4;
  localparam int unsigned CharW       = 8;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned DivBits     = 8;
  localparam int unsigned DivCycles   = ValueW / DivBits;
  localparam int unsigned StepW       = $clog2(DivCycles);

  localparam int unsigned MaxDigitsDefault = 64;
  localparam int unsigned MaxRadixDefault  = 16;

  localparam logic [CfgIdxW-1:0] CfgRadix   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCharsLo = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCharsHi = 2'd2;

  localparam logic [RadixW-1:0] RadixReset   = 5'd10;
  localparam logic [ValueW-1:0] CharsLoReset = 64'h3736353433323130;
  localparam logic [ValueW-1:0] CharsHiReset = 64'h6665646362613938;

  typedef struct packed {
    logic load;
    logic div_step;
    logic digit_done;
    logic rd_issue;
    logic out_load;
  } itrd_cmd_t;

  typedef struct packed {
    logic quot_zero;
    logic cnt_full;
    logic ptr_zero;
    logic out_free;
  } itrd_sts_t;

endpackage

// ===== rtl/core/itrd_ctrl.sv =====
`timescale 1ns / 1ps
module itrd_ctrl import itrd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_axis_tvalid,
  output logic      s_axis_tready,
  input  itrd_sts_t sts_i,
  output itrd_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StRead,
    StEmit
  } state_e;

  state_e             state_q;
  logic [StepW-1:0]   step_q;
  logic               step_last;

  assign step_last = (step_q == StepW'(DivCycles - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          step_q <= '0;
          if (s_axis_tvalid) begin
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (step_last) begin
            step_q <= '0;
            if (sts_i.quot_zero || sts_i.cnt_full) begin
              state_q <= StRead;
            end
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        StRead: begin
          state_q <= StEmit;
        end
        StEmit: begin
          if (sts_i.out_free) begin
            state_q <= sts_i.ptr_zero ? StIdle : StRead;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign s_axis_tready    = (state_q == StIdle);
  assign cmd_o.load       = (state_q == StIdle) && s_axis_tvalid;
  assign cmd_o.div_step   = (state_q == StDiv);
  assign cmd_o.digit_done = (state_q == StDiv) && step_last;
  assign cmd_o.rd_issue   = (state_q == StRead);
  assign cmd_o.out_load   = (state_q == StEmit) && sts_i.out_free;

endmodule

// ===== rtl/core/itrd_dpath.sv =====
`timescale 1ns / 1ps
module itrd_dpath import itrd_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MaxDigitsDefault,
  parameter int unsigned MAX_RADIX  = MaxRadixDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ValueW-1:0]   cfg_wdata_i,
  // input payload
  input  logic [ValueW-1:0]   in_value_i,
  input  logic                in_mode_i,
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [CharW-1:0]    m_axis_tdata,
  output logic                m_axis_tuser,
  output logic                m_axis_tlast,
  // control
  input  itrd_cmd_t           cmd_i,
  output itrd_sts_t           sts_o
);

  localparam int unsigned AddrW = $clog2(MAX_DIGITS);
  localparam int unsigned CntW  = $clog2(MAX_DIGITS + 1);

  logic [RadixW-1:0]  radix_q;
  logic [ValueW-1:0]  chars_lo_q;
  logic [ValueW-1:0]  chars_hi_q;
  logic [RadixW-1:0]  radix_eff;

  logic [ValueW-1:0]  quot_q, quot_d;
  logic [DigitW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]    cnt_q;
  logic [AddrW-1:0]   ptr_q;
  logic               neg_q;
  logic               first_q;

  logic [DigitW-1:0]  mem [MAX_DIGITS];
  logic [DigitW-1:0]  rdata_q;

  logic [2*ValueW-1:0] chars;
  logic                out_valid_q;
  logic [CharW-1:0]    out_char_q;
  logic                out_minus_q;
  logic                out_last_q;
  logic                in_neg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q    <= RadixReset;
      chars_lo_q <= CharsLoReset;
      chars_hi_q <= CharsHiReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRadix:   radix_q    <= cfg_wdata_i[RadixW-1:0];
        CfgCharsLo: chars_lo_q <= cfg_wdata_i;
        CfgCharsHi: chars_hi_q <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (radix_q < RadixW'(2)) begin
      radix_eff = RadixW'(2);
    end else if (radix_q > RadixW'(MAX_RADIX)) begin
      radix_eff = RadixW'(MAX_RADIX);
    end else begin
      radix_eff = radix_q;
    end
  end

  // restoring division, DivBits quotient bits per cycle
  always_comb begin
    logic [RadixW-1:0] t;
    logic              ge;
    quot_d = quot_q;
    rem_d  = rem_q;
    for (int b = 0; b < DivBits; b++) begin
      t      = {rem_d, quot_d[ValueW-1]};
      ge     = (t >= radix_eff);
      quot_d = {quot_d[ValueW-2:0], ge};
      rem_d  = ge ? DigitW'(t - radix_eff) : t[DigitW-1:0];
    end
  end

  assign in_neg = in_mode_i && in_value_i[ValueW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q  <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      ptr_q   <= '0;
      neg_q   <= 1'b0;
      first_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        quot_q  <= in_neg ? (~in_value_i + 1'b1) : in_value_i;
        rem_q   <= '0;
        cnt_q   <= '0;
        neg_q   <= in_neg;
        first_q <= 1'b1;
      end else if (cmd_i.div_step) begin
        quot_q <= quot_d;
        rem_q  <= cmd_i.digit_done ? '0 : rem_d;
        if (cmd_i.digit_done) begin
          cnt_q <= cnt_q + 1'b1;
          ptr_q <= cnt_q[AddrW-1:0];
        end
      end
      if (cmd_i.out_load) begin
        ptr_q   <= ptr_q - 1'b1;
        first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.digit_done) begin
      mem[cnt_q[AddrW-1:0]] <= rem_d;
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= mem[ptr_q];
    end
  end

  assign chars = {chars_hi_q, chars_lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_char_q  <= chars[{rdata_q, 3'b000} +: CharW];
      out_minus_q <= neg_q && first_q;
      out_last_q  <= (ptr_q == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tuser  = out_minus_q;
  assign m_axis_tlast  = out_last_q;

  assign sts_o.quot_zero = (quot_d == '0);
  assign sts_o.cnt_full  = (cnt_q == CntW'(MAX_DIGITS - 1));
  assign sts_o.ptr_zero  = (ptr_q == '0);
  assign sts_o.out_free  = !out_valid_q || m_axis_tready;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_DIGITS))
    else $error("digit count past store depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || m_axis_tready))
    else $error("output register overwritten before transfer");

  a_digit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.digit_done |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("digit count not advanced");

endmodule

// ===== rtl/core/integer_to_radix_digits_unit.sv =====
`timescale 1ns / 1ps
// Steps: each digit is one 64-bit restoring division by the radix, 8 quotient bits per
//   cycle; each result is then a digit store read and a character lookup.
//   D digits per number, D = 1..MAX_DIGITS.
// Throughput: one number at a time; next input taken once the last result is loaded.
// Reset: async active low; radix 10, digit table "0123456789abcdef", no output pending.
module integer_to_radix_digits_unit import itrd_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MaxDigitsDefault,
  parameter int unsigned MAX_RADIX  = MaxRadixDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ValueW-1:0]  cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [ValueW-1:0]  s_axis_tdata,   // [63:0] value
  input  logic               s_axis_tuser,   // [0] mode
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [CharW-1:0]   m_axis_tdata,   // [7:0] character
  output logic               m_axis_tuser,   // [0] lead_minus
  output logic               m_axis_tlast
);

  itrd_cmd_t cmd;
  itrd_sts_t sts;

  itrd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  itrd_dpath #(
    .MAX_DIGITS (MAX_DIGITS),
    .MAX_RADIX  (MAX_RADIX)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_value_i    (s_axis_tdata),
    .in_mode_i     (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

// ===== verif/integer_to_radix_digits_unit_test.sv =====
`timescale 1ns / 1ps
module integer_to_radix_digits_unit_test;
  import itrd_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned HoldOffCycles = 400;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             lead_minus;
    logic             is_last;
  } digit_beat_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgRadix;
  logic [ValueW-1:0]  cfg_wdata_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [ValueW-1:0]  s_axis_tdata = '0;   // [63:0] value
  logic               s_axis_tuser = 1'b0; // [0] mode
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [CharW-1:0]   m_axis_tdata;        // [7:0] character
  logic               m_axis_tuser;        // [0] lead_minus
  logic               m_axis_tlast;

  digit_beat_t       pending_digits[$];
  logic [RadixW-1:0] cur_radix = RadixReset;
  logic [ValueW-1:0] table_lo  = CharsLoReset;
  logic [ValueW-1:0] table_hi  = CharsHiReset;
  bit                gaps_on = 1'b1;
  int                hold_cycles = 0;
  int                mismatches = 0;
  int                numbers_sent = 0;
  int                digits_checked = 0;

  integer_to_radix_digits_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [CharW-1:0] char_of(logic [DigitW-1:0] d);
    if (d < 8) return table_lo[8*d +: 8];
    return table_hi[8*(d-8) +: 8];
  endfunction

  // Expected digit transfers for one number, most significant digit first.
  function automatic void expand_digits(logic [ValueW-1:0] value, logic mode);
    logic [ValueW-1:0] mag;
    logic [ValueW-1:0] base;
    logic [ValueW-1:0] rem;
    logic [DigitW-1:0] digs[MaxDigitsDefault];
    logic              neg;
    int                n;
    digit_beat_t       beat;
    base = {{(ValueW-RadixW){1'b0}}, cur_radix};
    if (base < 2) base = 2;
    if (base > MaxRadixDefault) base = MaxRadixDefault;
    neg = mode & value[ValueW-1];
    mag = neg ? (~value + 1'b1) : value;
    n = 0;
    do begin
      rem = mag % base;
      digs[n] = rem[DigitW-1:0];
      mag = mag / base;
      n++;
    end while (mag != 0 && n < MaxDigitsDefault);
    for (int i = 0; i < n; i++) begin
      beat.character  = char_of(digs[n-1-i]);
      beat.lead_minus = (i == 0) && neg;
      beat.is_last    = (i == n - 1);
      pending_digits.push_back(beat);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_number(input logic [ValueW-1:0] value, input logic mode);
    if (gaps_on && $urandom_range(0, 99) < 6) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = value;
    s_axis_tuser  = mode;
    do @(posedge clk_i); while (!s_axis_tready);
    expand_digits(value, mode);
    numbers_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid = 1'b0;
    while (pending_digits.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ValueW-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CfgRadix:   cur_radix = data[RadixW-1:0];
      CfgCharsLo: table_lo  = data;
      CfgCharsHi: table_hi  = data;
      default: ;
    endcase
  endtask

  task automatic send_random;
    logic [ValueW-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = '1;
          2: v = {1'b1, {(ValueW-1){1'b0}}};
          default: v = {1'b0, {(ValueW-1){1'b1}}};
        endcase
        send_number(v, 1'($urandom_range(0, 1)));
      end
      1: begin
        v = {$urandom_range(1, 1000)};
        send_number(~v + 1'b1, 1'b1);
      end
      default: begin
        v = {$urandom, $urandom};
        send_number(v >> $urandom_range(0, 63), 1'($urandom_range(0, 1)));
      end
    endcase
  endtask

  // Reset digit table, radix 10: zero, boundaries, sign handling.
  task automatic test_reset_config;
    send_number('0, 1'b0);
    send_number(64'd1, 1'b0);
    send_number(64'd9, 1'b0);
    send_number(64'd10, 1'b0);
    send_number('1, 1'b0);
    send_number('1, 1'b1);
    send_number(64'h8000_0000_0000_0000, 1'b1);
    send_number(64'h8000_0000_0000_0000, 1'b0);
    send_number(64'h7fff_ffff_ffff_ffff, 1'b1);
    send_number(64'hffff_ffff_ffff_fff6, 1'b1);
    send_number(64'd123456789, 1'b1);
    drain;
  endtask

  // Radix and digit table extremes, longest runs.
  task automatic test_config_extremes;
    write_reg(CfgRadix, 64'd2);
    send_number('1, 1'b0);
    send_number(64'h8000_0000_0000_0000, 1'b1);
    send_number('0, 1'b1);
    send_number(64'd5, 1'b1);
    drain;
    write_reg(CfgRadix, 64'd16);
    write_reg(CfgCharsLo, '1);
    write_reg(CfgCharsHi, '0);
    send_number(64'hfedc_ba98_7654_3210, 1'b0);
    send_number(64'h0123_4567_89ab_cdef, 1'b1);
    drain;
    write_reg(CfgCharsLo, '0);
    write_reg(CfgCharsHi, '1);
    send_number('1, 1'b0);
    send_number(64'h8000_0000_0000_0000, 1'b1);
    drain;
    write_reg(CfgRadix, 64'd3);
    send_number('1, 1'b0);
    drain;
  endtask

  task automatic test_random_numbers;
    logic [RadixW-1:0] r;
    for (int phase = 0; phase < 8; phase++) begin
      drain;
      r = (phase == 0) ? 5'd2 : (phase == 1) ? 5'd16 : 5'($urandom_range(2, 16));
      write_reg(CfgRadix, {{(ValueW-RadixW){1'b0}}, r});
      if (phase == 2) begin
        write_reg(CfgCharsLo, CharsLoReset);
        write_reg(CfgCharsHi, CharsHiReset);
      end else begin
        write_reg(CfgCharsLo, {$urandom, $urandom});
        write_reg(CfgCharsHi, {$urandom, $urandom});
      end
      @(posedge clk_i);
      gaps_on = (phase != 3);
      @(negedge clk_i);
      repeat (48) send_random();
    end
    drain;
    @(posedge clk_i);
    gaps_on = 1'b1;
    @(negedge clk_i);
  endtask

  // Output held off while numbers keep arriving: input must stall.
  task automatic test_output_backpressure;
    drain;
    @(posedge clk_i);
    hold_cycles = HoldOffCycles;
    @(negedge clk_i);
    repeat (6) send_random();
    drain;
  endtask

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready = 1'b0;
      hold_cycles--;
    end else begin
      m_axis_tready = !(gaps_on && $urandom_range(0, 99) < 6);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      digit_beat_t exp_beat;
      if (pending_digits.size() == 0) begin
        report_mismatch($sformatf("unexpected digit transfer char=%02h", m_axis_tdata));
      end else begin
        exp_beat = pending_digits.pop_front();
        digits_checked++;
        if (m_axis_tdata !== exp_beat.character)
          report_mismatch($sformatf("character %02h, want %02h",
                                    m_axis_tdata, exp_beat.character));
        if (m_axis_tuser !== exp_beat.lead_minus)
          report_mismatch($sformatf("lead_minus %b, want %b",
                                    m_axis_tuser, exp_beat.lead_minus));
        if (m_axis_tlast !== exp_beat.is_last)
          report_mismatch($sformatf("last %b, want %b", m_axis_tlast, exp_beat.is_last));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, quiet);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_config();
    test_config_extremes();
    test_random_numbers();
    test_output_backpressure();
    drain;
    repeat (30) @(negedge clk_i);
    $display("%0d numbers converted into %0d checked digit transfers", numbers_sent,
             digits_checked);
    $display("covered: radix 2..16, signed/unsigned, extreme values, digit tables, stalls");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
